// ===== rtl/strict_priority_fifo_queue_assert.svh =====
// Assertion helpers for the priority queue RTL.
// SPQ_ASSERT_IMP: same-cycle implication, SPQ_ASSERT_NXT: next-cycle implication.
`ifndef STRICT_PRIORITY_FIFO_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_FIFO_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int SPQ_MAX_LEVELS  = 8;
    localparam int SPQ_CAPACITY    = 64;
    localparam int SPQ_HANDLE_BITS = 32;

    // fixed field widths of the channels
    localparam int HANDLE_W = 32;
    localparam int PRIO_W   = 3;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd8;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BADPRIO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef logic [CFG_W-1:0] t_levels;

    typedef struct packed {
        t_cmd                command;
        logic [HANDLE_W-1:0] task_handle;
        logic [PRIO_W-1:0]   priority_req;
    } t_spq_req;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] popped_handle;
        logic [PRIO_W-1:0]   popped_level;
        logic [COUNT_W-1:0]  queued_count;
        logic [HANDLE_W-1:0] pushes_total;
    } t_spq_rsp;

    // slot allocator control
    typedef struct packed {
        logic take;
        logic give;
    } t_alloc_ctl;

endpackage

// ===== rtl/spq_stream_if.sv =====
interface spq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/spq_slot_store.sv =====
module spq_slot_store #(
    parameter int CAPACITY   = 64,
    parameter int STORE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    input  logic                        i_link_we,
    input  logic [$clog2(CAPACITY)-1:0] i_link_addr,
    input  logic [$clog2(CAPACITY)-1:0] i_link_data,
    input  logic                        i_hdl_we,
    input  logic [$clog2(CAPACITY)-1:0] i_hdl_addr,
    input  logic [STORE_BITS-1:0]       i_hdl_data,
    output logic [$clog2(CAPACITY)-1:0] o_link_rd,
    output logic [STORE_BITS-1:0]       o_hdl_rd
);
    localparam int SLOT_W = $clog2(CAPACITY);

    logic [SLOT_W-1:0]     r_link_mem [CAPACITY];
    logic [STORE_BITS-1:0] r_hdl_mem  [CAPACITY];
    logic [SLOT_W-1:0]     r_link_rd;
    logic [STORE_BITS-1:0] r_hdl_rd;

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            r_link_mem[i_link_addr] <= i_link_data;
        end
        r_link_rd <= r_link_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_hdl_we) begin
            r_hdl_mem[i_hdl_addr] <= i_hdl_data;
        end
        r_hdl_rd <= r_hdl_mem[i_rd_addr];
    end

    assign o_link_rd = r_link_rd;
    assign o_hdl_rd  = r_hdl_rd;

endmodule

// ===== rtl/spq_alloc.sv =====
`include "strict_priority_fifo_queue_assert.svh"

module spq_alloc
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_alloc_ctl                  i_ctl,
    input  logic [$clog2(CAPACITY)-1:0] i_give_slot,
    output logic [$clog2(CAPACITY)-1:0] o_slot
);
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    // freed slots go on a stack; untouched slots come from a fill counter
    logic [SLOT_W-1:0] r_stack [CAPACITY];
    logic [SLOT_W-1:0] r_top_rd;
    logic [CNT_W-1:0]  r_sp;
    logic [CNT_W-1:0]  r_fresh;
    logic [CNT_W-1:0]  w_sp_dec;

    assign w_sp_dec = r_sp - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.give) begin
            r_stack[r_sp[SLOT_W-1:0]] <= i_give_slot;
        end
        r_top_rd <= r_stack[w_sp_dec[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp    <= '0;
            r_fresh <= '0;
        end else if (i_ctl.give) begin
            r_sp <= r_sp + CNT_W'(1);
        end else if (i_ctl.take) begin
            if (r_sp != '0) begin
                r_sp <= w_sp_dec;
            end else begin
                r_fresh <= r_fresh + CNT_W'(1);
            end
        end
    end

    assign o_slot = (r_sp != '0) ? r_top_rd : r_fresh[SLOT_W-1:0];

    `SPQ_ASSERT_IMP(a_stack_le_fresh, i_clk, i_rst_n, 1'b1, r_sp <= r_fresh, "stack over fill")
    `SPQ_ASSERT_IMP(a_take_avail, i_clk, i_rst_n, i_ctl.take, (r_sp != '0) || (r_fresh < CAP_C), "take with no free slot")
    `SPQ_ASSERT_IMP(a_one_op, i_clk, i_rst_n, i_ctl.give, !i_ctl.take, "take and give together")

endmodule

// ===== rtl/strict_priority_fifo_queue.sv =====
// Strict priority queue of task handles. Up to MAX_LEVELS FIFO levels share
// one linked store of CAPACITY slots; a push appends to its level, a pop
// takes the oldest entry of the highest non-empty level below the configured
// level count (register value 0 counts as 1, values above MAX_LEVELS clamp).
// Every request gets exactly one response: status, popped handle and level,
// entries held afterwards and a wrapping count of accepted pushes. Requests
// are taken one at a time. The idle cycle presents the head slot of the top
// level and the top of the free-slot stack to the registered-read link,
// handle and free-stack memories; the update state that follows commits all
// writes and loads the response register. A response register that is still
// occupied holds the sequencer in its update cycle until it is taken. The
// level-count register takes a transfer on every cycle and must only be
// written while the queue is idle. No clearing pass is needed after reset.
`include "strict_priority_fifo_queue_assert.svh"

module strict_priority_fifo_queue
    import spq_pkg::*;
#(
    parameter int MAX_LEVELS  = SPQ_MAX_LEVELS,
    parameter int CAPACITY    = SPQ_CAPACITY,
    parameter int HANDLE_BITS = SPQ_HANDLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_stream_if.sink   i_req,
    spq_stream_if.sink   i_cfg,
    spq_stream_if.source o_rsp
);
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int STORE_BITS = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [4:0]       MAXL  = 5'(MAX_LEVELS);

    // one-hot sequencer
    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } t_state;

    t_state r_state, n_state;

    // request latched at transfer
    t_cmd                  r_cmd;
    logic [STORE_BITS-1:0] r_handle;
    logic [LVL_W-1:0]      r_prio;
    t_status               r_status;

    // config and per-level tables
    t_levels               r_levels;
    logic [SLOT_W-1:0]     r_head [MAX_LEVELS];
    logic [SLOT_W-1:0]     r_tail [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] r_nonempty;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [HANDLE_W-1:0]   r_pushes, n_pushes;

    // response register
    logic     r_out_valid;
    t_spq_rsp r_rsp;

    logic [4:0]            w_eff;
    logic [LVL_W-1:0]      w_top;
    logic                  w_found;
    logic [LVL_W-1:0]      w_idx;
    logic [SLOT_W-1:0]     w_head, w_tail;
    logic                  w_ne;
    logic                  w_acc, w_commit, w_push_ok, w_pop_ok;
    t_status               w_status;
    logic [SLOT_W-1:0]     w_free_slot;
    logic [SLOT_W-1:0]     w_link_rd;
    logic [STORE_BITS-1:0] w_hdl_rd;
    t_alloc_ctl            w_actl;

    // effective level count, clamped to 1..MAX_LEVELS
    always_comb begin
        if (r_levels == '0) begin
            w_eff = 5'd1;
        end else if ({1'b0, r_levels} > MAXL) begin
            w_eff = MAXL;
        end else begin
            w_eff = {1'b0, r_levels};
        end
    end

    // highest non-empty level in use
    always_comb begin
        w_top   = '0;
        w_found = 1'b0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (r_nonempty[i] && (5'(i) < w_eff)) begin
                w_top   = LVL_W'(i);
                w_found = 1'b1;
            end
        end
    end

    // one table port: top level while idle or popping, else the push level
    assign w_idx  = ((r_state == S_IDLE) || (r_cmd == CMD_POP)) ? w_top : r_prio;
    assign w_head = r_head[w_idx];
    assign w_tail = r_tail[w_idx];
    assign w_ne   = r_nonempty[w_idx];

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_acc       = i_req.valid && i_req.ready;

    // status decided at transfer; bad priority wins over full
    always_comb begin
        if (i_req.data.command == CMD_POP) begin
            w_status = w_found ? ST_OK : ST_EMPTY;
        end else if ({2'b00, i_req.data.priority_req} >= w_eff) begin
            w_status = ST_BADPRIO;
        end else if (r_count >= CAP_C) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_OK;
        end
    end

    assign w_commit  = (r_state == S_UPDATE) && (!r_out_valid || o_rsp.ready);
    assign w_push_ok = (r_cmd == CMD_PUSH) && (r_status == ST_OK);
    assign w_pop_ok  = (r_cmd == CMD_POP) && (r_status == ST_OK);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_pushes = r_pushes;
        if (w_push_ok) begin
            n_count  = r_count + CNT_W'(1);
            n_pushes = r_pushes + HANDLE_W'(1);
        end else if (w_pop_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_levels    <= LEVELS_RESET;
            r_nonempty  <= '0;
            r_count     <= '0;
            r_pushes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_levels <= i_cfg.data;
            end
            if (w_commit) begin
                r_count     <= n_count;
                r_pushes    <= n_pushes;
                r_out_valid <= 1'b1;
                if (w_push_ok) begin
                    r_nonempty[w_idx] <= 1'b1;
                end else if (w_pop_ok && (w_head == w_tail)) begin
                    r_nonempty[w_idx] <= 1'b0;
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: request latch, head/tail tables, response
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd    <= i_req.data.command;
            r_handle <= i_req.data.task_handle[STORE_BITS-1:0];
            r_prio   <= LVL_W'(i_req.data.priority_req);
            r_status <= w_status;
        end
        if (w_commit) begin
            if (w_push_ok) begin
                if (!w_ne) begin
                    r_head[w_idx] <= w_free_slot;
                end
                r_tail[w_idx] <= w_free_slot;
            end else if (w_pop_ok && (w_head != w_tail)) begin
                r_head[w_idx] <= w_link_rd;
            end
            r_rsp.status        <= r_status;
            r_rsp.popped_handle <= w_pop_ok ? HANDLE_W'(w_hdl_rd) : '0;
            r_rsp.popped_level  <= w_pop_ok ? PRIO_W'(w_top) : '0;
            r_rsp.queued_count  <= COUNT_W'(n_count);
            r_rsp.pushes_total  <= n_pushes;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // slot allocation: push takes a slot, pop returns the head slot
    assign w_actl.take = w_commit && w_push_ok;
    assign w_actl.give = w_commit && w_pop_ok;

    spq_alloc #(
        .CAPACITY (CAPACITY)
    ) u_alloc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_actl),
        .i_give_slot (w_head),
        .o_slot      (w_free_slot)
    );

    spq_slot_store #(
        .CAPACITY   (CAPACITY),
        .STORE_BITS (STORE_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_addr   (w_head),
        .i_link_we   (w_commit && w_push_ok && w_ne),
        .i_link_addr (w_tail),
        .i_link_data (w_free_slot),
        .i_hdl_we    (w_commit && w_push_ok),
        .i_hdl_addr  (w_free_slot),
        .i_hdl_data  (r_handle),
        .o_link_rd   (w_link_rd),
        .o_hdl_rd    (w_hdl_rd)
    );

    `SPQ_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP_C, "entry count above capacity")
    `SPQ_ASSERT_IMP(a_empty_levels, i_clk, i_rst_n, r_count == '0, r_nonempty == '0, "level flagged with no entries")
    `SPQ_ASSERT_IMP(a_pop_level, i_clk, i_rst_n, w_commit && w_pop_ok, w_ne, "pop from an empty level")
    `SPQ_ASSERT_NXT(a_fail_nohandle, i_clk, i_rst_n, w_commit && (r_status != ST_OK), r_rsp.popped_handle == '0, "handle on failed request")

endmodule
